FILE: hdl/amtc_pkg.sv
// Shared types and constants for the adjacency matrix triangle check block.
// Depends on nothing; imported by the controller, the datapath and the top level.
package amtc_pkg;

  localparam int MAX_VERTICES   = 64;
  localparam int VIDX_BITS      = 6;
  localparam int WEIGHT_BITS    = 16;
  localparam int WEIGHT_IN_BITS = 16;
  localparam int VCOUNT_BITS    = 7;
  localparam int EDGE_BITS      = 12;
  localparam int NZ_BITS        = 4;
  localparam logic [EDGE_BITS-1:0]   COUNTER_MAX    = 12'd4095;
  localparam logic [NZ_BITS-1:0]     COMPLETE_COUNT = 4'd6;
  localparam logic [VCOUNT_BITS-1:0] VCOUNT_RESET   = 7'd64;

  // Request modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_CHECK  = 1'b1;

  typedef struct packed {
    logic                              mode;
    logic [VIDX_BITS-1:0]              vertex_a;
    logic [VIDX_BITS-1:0]              vertex_b;
    logic [VIDX_BITS-1:0]              vertex_c;
    logic signed [WEIGHT_IN_BITS-1:0]  weight;
  } request_t;

  typedef struct packed {
    logic                 is_complete;
    logic                 invalid_vertex;
    logic [EDGE_BITS-1:0] edge_total;
  } result_t;

  // Which captured vertex selects the matrix row
  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } row_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     capture;
    logic     mem_rd;
    logic     mem_wr;
    logic     accum;
    logic     push;
    row_sel_t row_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic invalid;
    logic check;
    logic out_free;
  } status_t;

  // Nonzero test on the kept low WEIGHT_BITS bits of the sign-extended weight
  function automatic logic weight_nonzero(input logic signed [WEIGHT_IN_BITS-1:0] w);
    logic nz;
    nz = 1'b0;
    for (int i = 0; i < WEIGHT_IN_BITS; i++) begin
      if (i < WEIGHT_BITS) begin
        nz = nz | w[i];
      end
    end
    return nz;
  endfunction

endpackage

FILE: hdl/amtc_ctrl.sv
// Sequencer for the adjacency matrix triangle check block.
// Depends on amtc_pkg; drives the datapath through cmd_t and reads status_t.
module amtc_ctrl import amtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_A,
    S_WR_A,
    S_RD_B,
    S_WR_B,
    S_CK_B,
    S_CK_C,
    S_CK_END,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_RD_A;
      S_RD_A: begin
        if (status.invalid)    state_next = S_DONE;
        else if (status.check) state_next = S_CK_B;
        else                   state_next = S_WR_A;
      end
      S_WR_A:   state_next = S_RD_B;
      S_RD_B:   state_next = S_WR_B;
      S_WR_B:   state_next = S_DONE;
      S_CK_B:   state_next = S_CK_C;
      S_CK_C:   state_next = S_CK_END;
      S_CK_END: state_next = S_DONE;
      S_DONE:   if (status.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Commands decoded from the state
  always_comb begin
    cmd         = '0;
    cmd.row_sel = SEL_A;
    unique case (state)
      S_IDLE:   cmd.capture = in_valid;
      S_RD_A:   cmd.mem_rd  = 1'b1;
      S_WR_A:   cmd.mem_wr  = 1'b1;
      S_RD_B: begin
        cmd.mem_rd  = 1'b1;
        cmd.row_sel = SEL_B;
      end
      S_WR_B: begin
        cmd.mem_wr  = 1'b1;
        cmd.row_sel = SEL_B;
      end
      S_CK_B: begin
        cmd.accum   = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.row_sel = SEL_B;
      end
      S_CK_C: begin
        cmd.accum   = 1'b1;
        cmd.mem_rd  = 1'b1;
        cmd.row_sel = SEL_C;
      end
      S_CK_END: cmd.accum = 1'b1;
      S_DONE:   cmd.push  = status.out_free;
      default:  cmd       = '0;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // An accepted request always starts with the row A read
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_RD_A))
    else $error("accepted request did not start the row A read");

  // A result is pushed only into a free output register
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> status.out_free)
    else $error("push into an occupied output register");

endmodule

FILE: hdl/amtc_datapath.sv
// Request register, matrix row memory, counters and output register.
// Depends on amtc_pkg; commanded by amtc_ctrl.
module amtc_datapath import amtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  request_t               in_data,
  input  logic                   cfg_write_en,
  input  logic [VCOUNT_BITS-1:0] cfg_write_data,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output result_t                out_data
);

  // Each row holds one nonzero flag per column; a row not yet valid reads as zero
  logic [MAX_VERTICES-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] row_valid;
  logic [MAX_VERTICES-1:0] rd_data;
  logic                    rd_row_valid;

  request_t               req;
  logic                   req_invalid;
  logic                   req_nz;
  logic [VCOUNT_BITS-1:0] vertex_count;
  logic [EDGE_BITS-1:0]   edge_counter;
  logic [NZ_BITS-1:0]     nz_count;

  logic                   in_invalid;
  logic [VIDX_BITS-1:0]   row;
  logic [VIDX_BITS-1:0]   col;
  logic [MAX_VERTICES-1:0] row_eff;
  logic [MAX_VERTICES-1:0] wr_data;
  logic [NZ_BITS-1:0]     row_hits;

  function automatic logic vertex_ok(input logic [VIDX_BITS-1:0] v,
                                     input logic [VCOUNT_BITS-1:0] n);
    return ({1'b0, v} < n) && (32'(v) < MAX_VERTICES);
  endfunction

  assign in_invalid = !vertex_ok(in_data.vertex_a, vertex_count) ||
                      !vertex_ok(in_data.vertex_b, vertex_count) ||
                      ((in_data.mode == MODE_CHECK) &&
                       !vertex_ok(in_data.vertex_c, vertex_count));

  // Row and column selection
  always_comb begin
    row = req.vertex_a;
    col = req.vertex_b;
    unique case (cmd.row_sel)
      SEL_A: begin
        row = req.vertex_a;
        col = req.vertex_b;
      end
      SEL_B: begin
        row = req.vertex_b;
        col = req.vertex_a;
      end
      SEL_C: begin
        row = req.vertex_c;
        col = req.vertex_a;
      end
      default: begin
        row = req.vertex_a;
        col = req.vertex_b;
      end
    endcase
  end

  // Merge the new flag into the row just read
  always_comb begin
    row_eff      = rd_row_valid ? rd_data : '0;
    wr_data      = row_eff;
    wr_data[col] = req_nz;
    row_hits     = NZ_BITS'(row_eff[req.vertex_a]) + NZ_BITS'(row_eff[req.vertex_b]) +
                   NZ_BITS'(row_eff[req.vertex_c]);
  end

  // Capture request and configuration
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req         <= in_data;
      req_invalid <= in_invalid;
      req_nz      <= weight_nonzero(in_data.weight);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
    end else if (cfg_write_en) begin
      vertex_count <= cfg_write_data;
    end
  end

  // Row memory: one access per cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[row] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data      <= mem[row];
      rd_row_valid <= row_valid[row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.mem_wr) begin
      row_valid[row] <= 1'b1;
    end
  end

  // Count an insert whose old entry at (a,b) was zero, whatever its weight; saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_counter <= '0;
    end else if (cmd.mem_wr && (cmd.row_sel == SEL_A) && !row_eff[col] &&
                 (edge_counter < COUNTER_MAX)) begin
      edge_counter <= edge_counter + 1'b1;
    end
  end

  // Accumulate nonzero entries over the three rows
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      nz_count <= '0;
    end else if (cmd.accum) begin
      nz_count <= nz_count + row_hits;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data.is_complete    <= !req_invalid && (req.mode == MODE_CHECK) &&
                                 (nz_count == COMPLETE_COUNT);
      out_data.invalid_vertex <= req_invalid;
      out_data.edge_total     <= edge_counter;
    end
  end

  assign status.invalid  = req_invalid;
  assign status.check    = (req.mode == MODE_CHECK);
  assign status.out_free = !out_valid || out_ready;

  // No memory write for a request with a bad vertex
  a_no_bad_write: assert property (@(posedge clk) disable iff (rst)
    cmd.mem_wr |-> !req_invalid)
    else $error("matrix written for an invalid request");

  // The edge counter moves by one at most
  a_counter_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (edge_counter != $past(edge_counter))) |->
      (edge_counter == $past(edge_counter) + 1'b1))
    else $error("edge counter jumped");

  // The edge counter moves only after a row A write
  a_counter_cause: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (edge_counter != $past(edge_counter))) |->
      $past(cmd.mem_wr && (cmd.row_sel == SEL_A)))
    else $error("edge counter changed without an insert");

endmodule

FILE: hdl/adjacency_matrix_triangle_check_core.sv
// Channel   Signals                          Payload
// in        in_valid / in_ready              in_data  (request_t)
// out       out_valid / out_ready            out_data (result_t)
// config    cfg_write_en                     cfg_write_data (vertex count)
//
// Each valid request holds the block from the accepting cycle through four
// steps on the single-port row memory (insert: read/write row A,
// read/write row B; check: read rows A, B, C plus one accumulate), then the
// push into the output register from the done state.
// A request with an out-of-range vertex reads row A, writes nothing and goes
// straight on to the push.
// Synchronous reset clears the row valid flags, so no clearing pass is needed.
// A result waiting on out_ready holds the push; the next request is taken once it is stored.
// Top level; depends on amtc_pkg, amtc_ctrl and amtc_datapath.
module adjacency_matrix_triangle_check_core import amtc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  request_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output result_t                out_data,
  input  logic                   cfg_write_en,
  input  logic [VCOUNT_BITS-1:0] cfg_write_data
);

  cmd_t    cmd;
  status_t status;

  // Sequencer
  amtc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and arithmetic
  amtc_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_data        (in_data),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data)
  );

endmodule
